[rtl/ppmc_pkg.sv]
// ----------------------------------------------------------------------------
// ppmc_pkg
// shared constants, types and helpers of the perspective point mapper
// ----------------------------------------------------------------------------
`default_nettype none

package ppmc_pkg;

	localparam int CAM_W         = 10;
	localparam int COEF_W        = 32;
	localparam int COORD_W       = 12;
	localparam int CFG_COUNT     = 8;
	localparam int CFG_IDX_W     = $clog2(CFG_COUNT);

	localparam int SCREEN_WIDTH  = 1920;
	localparam int SCREEN_HEIGHT = 1080;

	// signed coefficient times zero-extended camera coordinate
	localparam int PROD_W        = COEF_W + CAM_W + 1;
	// two products plus a 32-bit term
	localparam int SUM_W         = PROD_W + 1;
	// magnitude of a positive numerator or denominator
	localparam int NUM_W         = SUM_W - 1;
	localparam int DEN_W         = NUM_W;
	// Q16.16 numerator over Q2.30 denominator gives an integer after << 14
	localparam int FRAC_SHIFT    = 14;
	localparam int REM_W         = NUM_W + FRAC_SHIFT;
	localparam int Q_W           = COORD_W;
	localparam int Q_IDX_W       = $clog2(Q_W);
	localparam int DIV_STAGES    = Q_W;

	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SUM_W-1:0]  ONE_Q30  = SUM_W'(1) << 30;
	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_X_FROM_X,
		REG_GAIN_X_FROM_Y,
		REG_OFFSET_X,
		REG_GAIN_Y_FROM_X,
		REG_GAIN_Y_FROM_Y,
		REG_OFFSET_Y,
		REG_PERSP_FROM_X,
		REG_PERSP_FROM_Y
	} cfg_reg_t;

	typedef logic [CFG_COUNT-1:0][COEF_W-1:0] coef_bank_t;

	// how one axis of a point gets resolved in the back end
	typedef enum logic [1:0] {
		AXIS_DIVIDE,
		AXIS_ZERO,
		AXIS_SAT
	} axis_cls_t;

	// classified point handed from front end to back end
	typedef struct packed {
		logic              bad;
		axis_cls_t         cls_x;
		axis_cls_t         cls_y;
		logic [NUM_W-1:0]  num_x;
		logic [NUM_W-1:0]  num_y;
		logic [DEN_W-1:0]  den;
	} map_job_t;

	// one stage of the restoring divider, both axes side by side
	typedef struct packed {
		logic              bad;
		axis_cls_t         cls_x;
		axis_cls_t         cls_y;
		logic [REM_W-1:0]  rem_x;
		logic [REM_W-1:0]  rem_y;
		logic [DEN_W-1:0]  den;
		logic [Q_W-1:0]    q_x;
		logic [Q_W-1:0]    q_y;
	} div_stage_t;

	function automatic logic [COEF_W-1:0] coef_reset(input cfg_reg_t idx);
		logic [COEF_W-1:0] v;
		case (idx)
			REG_GAIN_X_FROM_X: v = COEF_ONE;
			REG_GAIN_Y_FROM_Y: v = COEF_ONE;
			default:           v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/ppmc_front.sv]
// ----------------------------------------------------------------------------
// ppmc_front
// multiplies, sums and classifies each camera point into a divide job
// ----------------------------------------------------------------------------
`default_nettype none

module ppmc_front import ppmc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  coef_bank_t          coef,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CAM_W-1:0]    cam_x,
	input  logic [CAM_W-1:0]    cam_y,
	output logic                job_valid,
	input  logic                job_stall,
	output map_job_t            job
);

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     ready_s1, ready_s2, ready_s3;
	logic signed [PROD_W-1:0] p_ax_s1, p_by_s1, p_dx_s1, p_ey_s1, p_gx_s1, p_hy_s1;
	logic signed [COEF_W-1:0] c_s1, f_s1;
	logic signed [SUM_W-1:0]  num_x_s2, num_y_s2, den_s2;
	map_job_t                 job_s3, job_d;

	function automatic axis_cls_t classify(input logic signed [SUM_W-1:0] num,
			input logic [DEN_W-1:0] den);
		logic [NUM_W+1:0] num4;
		axis_cls_t        c;
		num4 = {num[NUM_W-1:0], 2'b00};
		if (num[SUM_W-1] || num == '0) begin
			c = AXIS_ZERO;
		end else if (num4 >= (NUM_W+2)'(den)) begin
			// quotient would reach 4096 or more
			c = AXIS_SAT;
		end else begin
			c = AXIS_DIVIDE;
		end
		return c;
	endfunction

	assign ready_s3 = !valid_s3 || !job_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			p_ax_s1 <= $signed(coef[REG_GAIN_X_FROM_X]) * $signed({1'b0, cam_x});
			p_by_s1 <= $signed(coef[REG_GAIN_X_FROM_Y]) * $signed({1'b0, cam_y});
			p_dx_s1 <= $signed(coef[REG_GAIN_Y_FROM_X]) * $signed({1'b0, cam_x});
			p_ey_s1 <= $signed(coef[REG_GAIN_Y_FROM_Y]) * $signed({1'b0, cam_y});
			p_gx_s1 <= $signed(coef[REG_PERSP_FROM_X]) * $signed({1'b0, cam_x});
			p_hy_s1 <= $signed(coef[REG_PERSP_FROM_Y]) * $signed({1'b0, cam_y});
			c_s1    <= $signed(coef[REG_OFFSET_X]);
			f_s1    <= $signed(coef[REG_OFFSET_Y]);
		end
	end

	// sums
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			num_x_s2 <= SUM_W'(p_ax_s1) + SUM_W'(p_by_s1) + SUM_W'(c_s1);
			num_y_s2 <= SUM_W'(p_dx_s1) + SUM_W'(p_ey_s1) + SUM_W'(f_s1);
			den_s2   <= SUM_W'(p_gx_s1) + SUM_W'(p_hy_s1) + $signed(ONE_Q30);
		end
	end

	always_comb begin
		job_d.bad   = den_s2[SUM_W-1] || den_s2 == '0;
		job_d.den   = den_s2[DEN_W-1:0];
		job_d.num_x = num_x_s2[NUM_W-1:0];
		job_d.num_y = num_y_s2[NUM_W-1:0];
		job_d.cls_x = classify(num_x_s2, den_s2[DEN_W-1:0]);
		job_d.cls_y = classify(num_y_s2, den_s2[DEN_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			job_s3 <= job_d;
		end
	end

	assign job_valid = valid_s3;
	assign job       = job_s3;

endmodule

`default_nettype wire

[rtl/ppmc_queue.sv]
// ----------------------------------------------------------------------------
// ppmc_queue
// short job queue between the front end and the divider
// ----------------------------------------------------------------------------
`default_nettype none

module ppmc_queue import ppmc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_stall,
	input  map_job_t push_job,
	output logic     pop_valid,
	input  logic     pop_stall,
	output map_job_t pop_job
);

	map_job_t               slot_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push, pop;

	assign push_stall = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

[rtl/ppmc_back.sv]
// ----------------------------------------------------------------------------
// ppmc_back
// pipelined restoring divider, one quotient bit per stage, then clamping
// ----------------------------------------------------------------------------
`default_nettype none

module ppmc_back import ppmc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_stall,
	input  map_job_t           job,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COORD_W-1:0] screen_x,
	output logic [COORD_W-1:0] screen_y,
	output logic               bad_denominator
);

	div_stage_t         stage_s   [DIV_STAGES];
	div_stage_t         stage_in  [DIV_STAGES];
	logic               stage_v_q [DIV_STAGES];
	logic               stage_vin [DIV_STAGES];
	logic               stage_rdy [DIV_STAGES];
	logic               out_valid_q, out_rdy;
	logic [COORD_W-1:0] screen_x_q, screen_y_q;
	logic               bad_q;

	function automatic div_stage_t div_step(input div_stage_t s,
			input logic [Q_IDX_W-1:0] shift);
		logic [REM_W-1:0] dsh;
		logic [REM_W:0]   tx, ty;
		div_stage_t       r;
		r   = s;
		dsh = REM_W'(s.den) << shift;
		tx  = {1'b0, s.rem_x} - {1'b0, dsh};
		ty  = {1'b0, s.rem_y} - {1'b0, dsh};
		if (!tx[REM_W]) begin
			r.rem_x      = tx[REM_W-1:0];
			r.q_x[shift] = 1'b1;
		end
		if (!ty[REM_W]) begin
			r.rem_y      = ty[REM_W-1:0];
			r.q_y[shift] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_axis(input axis_cls_t c,
			input logic [Q_W-1:0] q, input logic [COORD_W:0] size);
		logic [COORD_W-1:0] v;
		case (c)
			AXIS_SAT:    v = COORD_W'(size - 1'b1);
			AXIS_DIVIDE: v = ({1'b0, q} >= size) ? COORD_W'(size - 1'b1) : q;
			default:     v = '0;
		endcase
		return v;
	endfunction

	// entry into the first divider stage
	always_comb begin
		stage_in[0].bad   = job.bad;
		stage_in[0].cls_x = job.cls_x;
		stage_in[0].cls_y = job.cls_y;
		stage_in[0].rem_x = {job.num_x, FRAC_SHIFT'(0)};
		stage_in[0].rem_y = {job.num_y, FRAC_SHIFT'(0)};
		stage_in[0].den   = job.den;
		stage_in[0].q_x   = '0;
		stage_in[0].q_y   = '0;
	end
	assign stage_vin[0] = job_valid;
	assign job_stall    = !stage_rdy[0];

	assign out_rdy = !out_valid_q || !out_stall;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam logic [Q_IDX_W-1:0] SHIFT = Q_IDX_W'(DIV_STAGES - 1 - k);

		if (k > 0) begin : g_link
			assign stage_in[k]  = stage_s[k-1];
			assign stage_vin[k] = stage_v_q[k-1];
		end

		if (k == DIV_STAGES - 1) begin : g_last
			assign stage_rdy[k] = !stage_v_q[k] || out_rdy;
		end else begin : g_mid
			assign stage_rdy[k] = !stage_v_q[k] || stage_rdy[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_v_q[k] <= 1'b0;
			end else if (stage_rdy[k]) begin
				stage_v_q[k] <= stage_vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (stage_rdy[k] && stage_vin[k]) begin
				stage_s[k] <= div_step(stage_in[k], SHIFT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= stage_v_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && stage_v_q[DIV_STAGES-1]) begin
			if (stage_s[DIV_STAGES-1].bad) begin
				screen_x_q <= '0;
				screen_y_q <= '0;
				bad_q      <= 1'b1;
			end else begin
				screen_x_q <= clamp_axis(stage_s[DIV_STAGES-1].cls_x,
					stage_s[DIV_STAGES-1].q_x, (COORD_W+1)'(SCREEN_WIDTH));
				screen_y_q <= clamp_axis(stage_s[DIV_STAGES-1].cls_y,
					stage_s[DIV_STAGES-1].q_y, (COORD_W+1)'(SCREEN_HEIGHT));
				bad_q      <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign screen_x        = screen_x_q;
	assign screen_y        = screen_y_q;
	assign bad_denominator = bad_q;

endmodule

`default_nettype wire

[rtl/perspective_point_map_clamp.sv]
// ----------------------------------------------------------------------------
// perspective_point_map_clamp
// maps camera points to clamped screen points with a projective transform
// ----------------------------------------------------------------------------
// Takes one camera point per clock and returns one screen point per clock
// when neither side stalls. A point passes three front stages (multiply,
// sum, classify), one queue slot, twelve divider stages (one quotient bit
// each) and the output register. Throughput is set by the divider
// pipeline, which takes a new job every cycle it is not stalled. The eight
// coefficients sit in registers written through cfg_wr_en / cfg_index /
// cfg_data and must only change while no transaction is in flight. A point
// whose denominator is zero or negative comes out as 0,0 with
// bad_denominator set.
`default_nettype none

module perspective_point_map_clamp import ppmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// camera point channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CAM_W-1:0]      cam_x,
	input  logic [CAM_W-1:0]      cam_y,
	// screen point channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_W-1:0]    screen_x,
	output logic [COORD_W-1:0]    screen_y,
	output logic                  bad_denominator,
	// coefficient write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_W-1:0]     cfg_data
);

	coef_bank_t coef_q;
	logic       fq_valid, fq_stall;
	map_job_t   fq_job;
	logic       qb_valid, qb_stall;
	map_job_t   qb_job;

	// coefficient registers, index order as in the register map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++) begin
				coef_q[i] <= coef_reset(cfg_reg_t'(i));
			end
		end else if (cfg_wr_en) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// front end: products, sums, sign and range classification
	ppmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cam_x     (cam_x),
		.cam_y     (cam_y),
		.job_valid (fq_valid),
		.job_stall (fq_stall),
		.job       (fq_job)
	);

	// decouples the front end from divider back pressure
	ppmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_stall (fq_stall),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_stall  (qb_stall),
		.pop_job    (qb_job)
	);

	// back end: divider and clamp, ends in the output register
	ppmc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (qb_valid),
		.job_stall       (qb_stall),
		.job             (qb_job),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.screen_x        (screen_x),
		.screen_y        (screen_y),
		.bad_denominator (bad_denominator)
	);

endmodule

`default_nettype wire

[rtl/ppmc_check.sv]
// ----------------------------------------------------------------------------
// ppmc_check
// port-level checks of the perspective point mapper
// ----------------------------------------------------------------------------
`default_nettype none

module ppmc_check import ppmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [CAM_W-1:0]      cam_x,
	input  logic [CAM_W-1:0]      cam_y,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [COORD_W-1:0]    screen_x,
	input  logic [COORD_W-1:0]    screen_y,
	input  logic                  bad_denominator,
	input  logic                  cfg_wr_en
);

	// a flagged point always reports the origin
	a_bad_is_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_denominator |-> screen_x == '0 && screen_y == '0)
		else $error("flagged point not at origin");

	// results stay on screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, screen_x} < (COORD_W+1)'(SCREEN_WIDTH)
			&& {1'b0, screen_y} < (COORD_W+1)'(SCREEN_HEIGHT))
		else $error("screen point out of range");

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_x)
			&& $stable(screen_y) && $stable(bad_denominator))
		else $error("stalled result changed");

	// a stalled camera point transaction holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(cam_x) && $stable(cam_y))
		else $error("stalled camera point changed");

	// coefficients change only while no camera point or screen point is offered
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> !in_valid && !out_valid)
		else $error("coefficient write with a transaction in flight");

endmodule

bind perspective_point_map_clamp ppmc_check u_ppmc_check (.*);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the perspective point mapper
// ----------------------------------------------------------------------------
// Sends camera points through the block under random gaps on both sides and
// compares every screen point with a table literal or a bench mapping. A
// short table of hand-picked points and coefficient sets opens the run. The
// table covers identity, mirroring, clamping at both edges, zero and negative
// denominators and the coefficient extremes. Random phases follow, each with
// a fresh coefficient set that is written while the pipeline is empty.
// ----------------------------------------------------------------------------

module tb import ppmc_pkg::*; ();

	localparam int IDLE_PCT     = 35;
	localparam int HOLD_CYCLES  = 150;
	localparam int RAND_PHASES  = 18;
	localparam int PHASE_POINTS = 100;
	localparam int TAIL_CYCLES  = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DIR_COUNT    = 22;
	localparam int SET_COUNT    = 8;
	localparam logic [COEF_W-1:0] Q16_ONE = 32'd65536;

	// how a random phase picks its coefficients
	typedef enum {
		COEF_PLAUSIBLE,
		COEF_ANY,
		COEF_EXTREME
	} coef_mix_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               bad;
	} screen_pt_t;

	// one directed point: coefficient set, camera point, and a literal
	// expectation when known is set
	typedef struct packed {
		logic [2:0]         set;
		logic [CAM_W-1:0]   x;
		logic [CAM_W-1:0]   y;
		logic               known;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic               eb;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CAM_W-1:0]     cam_x;
	logic [CAM_W-1:0]     cam_y;
	logic                 out_valid;
	logic                 out_stall;
	logic [COORD_W-1:0]   screen_x;
	logic [COORD_W-1:0]   screen_y;
	logic                 bad_denominator;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	// mirror of the coefficient registers, and the next set to program
	logic [COEF_W-1:0] coef_mirror [CFG_COUNT];
	logic [COEF_W-1:0] coef_next   [CFG_COUNT];

	// screen points still owed by the block, oldest first
	screen_pt_t pending_points [$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  no_idle        = 1'b0;
	bit  hold_req       = 1'b0;

	// directed coefficient sets, in register order
	logic [COEF_W-1:0] coef_sets [SET_COUNT][CFG_COUNT] = '{
		// identity, same as after reset
		'{32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0},
		// mirrored axes, no quotient positive
		'{-32'd65536, 32'd0, 32'd0, 32'd0, -32'd65536, 32'd0, 32'd0, 32'd0},
		// scale by two, reaches the right and bottom edges
		'{32'd131072, 32'd0, 32'd0, 32'd0, 32'd131072, 32'd0, 32'd0, 32'd0},
		// no gains, largest offsets
		'{32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0},
		// denominator 1 - x, zero at x = 1
		'{32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'hC000_0000, 32'd0},
		// every coefficient at its largest
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
		// every coefficient at its smallest
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
		// a plausible keystone correction
		'{32'd70000, -32'd3000, 32'd5000000, 32'd2000,
		  32'd68000, -32'd4000000, 32'd30000, -32'd20000}
	};

	dir_row_t dir_rows [DIR_COUNT] = '{
		// reset coefficients: identity mapping
		'{3'd0, 10'd0,    10'd0,    1'b1, 12'd0,    12'd0,    1'b0},
		'{3'd0, 10'd1023, 10'd1023, 1'b1, 12'd1023, 12'd1023, 1'b0},
		'{3'd0, 10'd1023, 10'd0,    1'b1, 12'd1023, 12'd0,    1'b0},
		'{3'd0, 10'd0,    10'd1023, 1'b1, 12'd0,    12'd1023, 1'b0},
		'{3'd0, 10'd341,  10'd682,  1'b1, 12'd341,  12'd682,  1'b0},
		// negative quotients clamp to zero
		'{3'd1, 10'd1023, 10'd1023, 1'b1, 12'd0,    12'd0,    1'b0},
		'{3'd1, 10'd0,    10'd0,    1'b1, 12'd0,    12'd0,    1'b0},
		// just past and just inside the screen size
		'{3'd2, 10'd960,  10'd540,  1'b1, 12'd1919, 12'd1079, 1'b0},
		'{3'd2, 10'd959,  10'd539,  1'b1, 12'd1918, 12'd1078, 1'b0},
		// far beyond the screen size
		'{3'd3, 10'd512,  10'd512,  1'b1, 12'd1919, 12'd1079, 1'b0},
		// zero denominator, positive denominator, negative denominator
		'{3'd4, 10'd1,    10'd7,    1'b1, 12'd0,    12'd0,    1'b1},
		'{3'd4, 10'd0,    10'd7,    1'b1, 12'd0,    12'd7,    1'b0},
		'{3'd4, 10'd1023, 10'd1023, 1'b1, 12'd0,    12'd0,    1'b1},
		// largest coefficients
		'{3'd5, 10'd0,    10'd0,    1'b0, 12'd0,    12'd0,    1'b0},
		'{3'd5, 10'd1023, 10'd1023, 1'b0, 12'd0,    12'd0,    1'b0},
		'{3'd5, 10'd1023, 10'd0,    1'b0, 12'd0,    12'd0,    1'b0},
		// smallest coefficients
		'{3'd6, 10'd1023, 10'd1023, 1'b1, 12'd0,    12'd0,    1'b1},
		'{3'd6, 10'd0,    10'd0,    1'b1, 12'd0,    12'd0,    1'b0},
		// keystone
		'{3'd7, 10'd100,  10'd200,  1'b0, 12'd0,    12'd0,    1'b0},
		'{3'd7, 10'd1023, 10'd0,    1'b0, 12'd0,    12'd0,    1'b0},
		'{3'd7, 10'd0,    10'd1023, 1'b0, 12'd0,    12'd0,    1'b0},
		'{3'd7, 10'd512,  10'd768,  1'b0, 12'd0,    12'd0,    1'b0}
	};

	perspective_point_map_clamp u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cam_x           (cam_x),
		.cam_y           (cam_y),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.screen_x        (screen_x),
		.screen_y        (screen_y),
		.bad_denominator (bad_denominator),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit, far above the slowest correct run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d screen points outstanding",
				$time, pending_points.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// sign-extended coefficient
	function automatic longint coef_val(input cfg_reg_t r);
		return longint'(signed'(coef_mirror[r]));
	endfunction

	// truncating division, then clamp into 0..size-1
	function automatic logic [COORD_W-1:0] clamp_axis(input longint num,
			input longint den, input longint size);
		longint q;
		if (num <= 0)
			return '0;
		q = (num * 16384) / den;
		if (q >= size)
			q = size - 1;
		return q[COORD_W-1:0];
	endfunction

	// exact fixed-point projective mapping of one camera point
	function automatic screen_pt_t map_point(input logic [CAM_W-1:0] x,
			input logic [CAM_W-1:0] y);
		longint     lx, ly, nx, ny, den;
		screen_pt_t r;
		lx  = longint'(x);
		ly  = longint'(y);
		nx  = coef_val(REG_GAIN_X_FROM_X) * lx + coef_val(REG_GAIN_X_FROM_Y) * ly
			+ coef_val(REG_OFFSET_X);
		ny  = coef_val(REG_GAIN_Y_FROM_X) * lx + coef_val(REG_GAIN_Y_FROM_Y) * ly
			+ coef_val(REG_OFFSET_Y);
		den = coef_val(REG_PERSP_FROM_X) * lx + coef_val(REG_PERSP_FROM_Y) * ly
			+ (longint'(1) << 30);
		if (den <= 0) begin
			r = '{x: '0, y: '0, bad: 1'b1};
		end else begin
			r.x   = clamp_axis(nx, den, SCREEN_WIDTH);
			r.y   = clamp_axis(ny, den, SCREEN_HEIGHT);
			r.bad = 1'b0;
		end
		return r;
	endfunction

	function automatic int srange(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic logic [COEF_W-1:0] draw_coef(input cfg_reg_t r,
			input coef_mix_t mix);
		logic [COEF_W-1:0] v;
		case (mix)
			COEF_ANY: begin
				v = $urandom;
			end
			COEF_EXTREME: begin
				case ($urandom_range(5))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = 32'h0000_0000;
					3:       v = 32'hFFFF_FFFF;
					4:       v = 32'h0000_0001;
					default: v = Q16_ONE;
				endcase
			end
			default: begin
				// gains from a quarter to three, mild shear, offsets from -256 to 1024
				// pixels, perspective that keeps the denominator mostly positive
				case (r)
					REG_GAIN_X_FROM_X, REG_GAIN_Y_FROM_Y: v = srange(16384, 196608);
					REG_GAIN_X_FROM_Y, REG_GAIN_Y_FROM_X: v = srange(-32768, 32768);
					REG_OFFSET_X, REG_OFFSET_Y:           v = srange(-(256 << 16), 1024 << 16);
					default:                              v = srange(-524288, 524288);
				endcase
			end
		endcase
		return v;
	endfunction

	// write coef_next into all registers, one per cycle
	task automatic program_coefs();
		for (int r = 0; r < CFG_COUNT; r++) begin
			@(negedge clk);
			cfg_wr_en  <= 1'b1;
			cfg_index  <= cfg_reg_t'(r);
			cfg_data   <= coef_next[r];
			coef_mirror[r] = coef_next[r];
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// offer one camera point, hold it until the transaction completes
	task automatic send_point(input logic [CAM_W-1:0] x, input logic [CAM_W-1:0] y,
			input screen_pt_t want);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cam_x    <= x;
		cam_y    <= y;
		do
			@(posedge clk);
		while (in_stall);
		pending_points.push_back(want);
	endtask

	// stop offering and wait until every owed screen point has come out
	task automatic drain_points();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// screen point side: random stall, one long hold-off, and checking
	initial begin
		int         hold_left;
		bit         hold_taken;
		screen_pt_t want;
		hold_left  = 0;
		hold_taken = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// long hold-off so the pipeline fills and backs up the input
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
			end
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_points.size() == 0) begin
					$display("%0t: unexpected screen point x %0d y %0d bad %0b",
						$time, screen_x, screen_y, bad_denominator);
					mismatch_count++;
				end else begin
					want = pending_points.pop_front();
					if (screen_x !== want.x) begin
						$display("%0t: screen_x expected %0d, got %0d",
							$time, want.x, screen_x);
						mismatch_count++;
					end
					if (screen_y !== want.y) begin
						$display("%0t: screen_y expected %0d, got %0d",
							$time, want.y, screen_y);
						mismatch_count++;
					end
					if (bad_denominator !== want.bad) begin
						$display("%0t: bad_denominator expected %0b, got %0b",
							$time, want.bad, bad_denominator);
						mismatch_count++;
					end
				end
			end
		end
	end

	// camera point side: reset, directed table, then random phases
	initial begin
		int               cur_set;
		dir_row_t         row;
		screen_pt_t       want;
		coef_mix_t        mix;
		logic [CAM_W-1:0] px, py;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cam_x     = '0;
		cam_y     = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_GAIN_X_FROM_X;
		cfg_data  = '0;
		for (int r = 0; r < CFG_COUNT; r++)
			coef_mirror[r] = '0;
		coef_mirror[REG_GAIN_X_FROM_X] = Q16_ONE;
		coef_mirror[REG_GAIN_Y_FROM_Y] = Q16_ONE;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table; the first set runs on the reset coefficients
		cur_set = 0;
		for (int i = 0; i < DIR_COUNT; i++) begin
			row = dir_rows[i];
			if (int'(row.set) != cur_set) begin
				drain_points();
				cur_set   = int'(row.set);
				coef_next = coef_sets[cur_set];
				program_coefs();
			end
			if (row.known)
				want = '{x: row.ex, y: row.ey, bad: row.eb};
			else
				want = map_point(row.x, row.y);
			send_point(row.x, row.y, want);
		end

		// random phases, each with its own coefficient set
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p % 6 == 5)
				mix = COEF_ANY;
			else if (p % 6 == 2)
				mix = COEF_EXTREME;
			else
				mix = COEF_PLAUSIBLE;
			drain_points();
			// two phases run back to back with no gaps on either side
			no_idle = (p == 3 || p == 4);
			for (int r = 0; r < CFG_COUNT; r++)
				coef_next[r] = draw_coef(cfg_reg_t'(r), mix);
			program_coefs();
			if (p == 1)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_POINTS; k++) begin
				// mostly uniform points, now and then a sensor edge
				px = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0)
					: CAM_W'($urandom);
				py = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0)
					: CAM_W'($urandom);
				send_point(px, py, map_point(px, py));
			end
		end

		drain_points();
		// catch anything the block emits beyond what was owed
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
